// ===== sv/ascw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascw_pkg
// Shared constants, config struct and arctangent step table for the
// arctangent soft-clip waveshaper.
// ----------------------------------------------------------------------------
package ascw_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int CORDIC_STEPS    = 30;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    localparam int DRIVE_W  = 17;
    localparam int RANGE_W  = 12;
    localparam int BLEND_W  = 17;
    localparam int VOLUME_W = 18;
    localparam int DR_W     = DRIVE_W + RANGE_W;
    localparam int DRY_W    = BLEND_W + 1;
    localparam int Z_W      = 32;

    localparam logic [DRIVE_W-1:0]  DRIVE_RST  = 17'd65536;
    localparam logic [RANGE_W-1:0]  RANGE_RST  = 12'd1;
    localparam logic [BLEND_W-1:0]  BLEND_RST  = 17'd65536;
    localparam logic [VOLUME_W-1:0] VOLUME_RST = 18'd65536;
    localparam logic [DRY_W-1:0]    GAIN_ONE   = 18'd65536;

    typedef enum logic [2:0] {
        REG_DRIVE  = 3'd0,
        REG_RANGE  = 3'd1,
        REG_BLEND  = 3'd2,
        REG_VOLUME = 3'd3,
        REG_BYPASS = 3'd4
    } ascw_reg_e;

    typedef struct packed {
        logic [DR_W-1:0]            drive_range;
        logic [BLEND_W-1:0]         blend;
        logic signed [DRY_W-1:0]    dry_gain;
        logic [VOLUME_W-1:0]        volume;
        logic                       bypass;
    } ascw_cfg_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic signed [Z_W-1:0] atan_step(input int idx);
        logic signed [Z_W-1:0] t;
        unique case (idx)
            0:  t = 32'sd536870912;
            1:  t = 32'sd316933406;
            2:  t = 32'sd167458907;
            3:  t = 32'sd85004756;
            4:  t = 32'sd42667331;
            5:  t = 32'sd21354465;
            6:  t = 32'sd10679838;
            7:  t = 32'sd5340245;
            8:  t = 32'sd2670163;
            9:  t = 32'sd1335087;
            10: t = 32'sd667544;
            11: t = 32'sd333772;
            12: t = 32'sd166886;
            13: t = 32'sd83443;
            14: t = 32'sd41722;
            15: t = 32'sd20861;
            16: t = 32'sd10430;
            17: t = 32'sd5215;
            18: t = 32'sd2608;
            19: t = 32'sd1304;
            20: t = 32'sd652;
            21: t = 32'sd326;
            22: t = 32'sd163;
            23: t = 32'sd81;
            24: t = 32'sd41;
            25: t = 32'sd20;
            26: t = 32'sd10;
            27: t = 32'sd5;
            28: t = 32'sd3;
            29: t = 32'sd1;
            default: t = 32'sd0;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/ascw_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascw_in_if
// Sample input channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
interface ascw_in_if #(
    parameter int SAMPLE_BITS = ascw_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// ===== sv/ascw_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascw_out_if
// Result channel: valid/ready handshake with shaped sample and clip flag.
// ----------------------------------------------------------------------------
interface ascw_out_if #(
    parameter int SAMPLE_BITS = ascw_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          clipped;

    modport source (output valid, output out_sample, output clipped, input ready);
    modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

// ===== sv/ascw_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascw_cfg
// APB register file: gains, blend, volume, bypass, plus registered
// drive*range and dry-path gain derived from them.
// ----------------------------------------------------------------------------
module ascw_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ascw_pkg::ADDR_W-1:0] paddr,
    input  logic [ascw_pkg::DATA_W-1:0] pwdata,
    output logic [ascw_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output ascw_pkg::ascw_cfg_t         cfg
);
    import ascw_pkg::*;

    logic [DRIVE_W-1:0]      drive_reg;
    logic [RANGE_W-1:0]      range_reg;
    logic [BLEND_W-1:0]      blend_reg;
    logic [VOLUME_W-1:0]     volume_reg;
    logic                    bypass_reg;
    logic [DR_W-1:0]         dr_reg;
    logic [DR_W-1:0]         dr_next;
    logic signed [DRY_W-1:0] dry_reg;
    logic signed [DRY_W-1:0] dry_next;
    logic                    wr_en;
    logic [2:0]              idx;

    assign pready  = 1'b1;
    assign idx     = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign dr_next = DR_W'(drive_reg) * DR_W'(range_reg);
    assign dry_next = $signed(GAIN_ONE) - $signed(DRY_W'(blend_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg  <= DRIVE_RST;
            range_reg  <= RANGE_RST;
            blend_reg  <= BLEND_RST;
            volume_reg <= VOLUME_RST;
            bypass_reg <= 1'b0;
            dr_reg     <= DR_W'(DRIVE_RST);
            dry_reg    <= '0;
        end
        else
        begin
            dr_reg  <= dr_next;
            dry_reg <= dry_next;
            if (wr_en)
            begin
                unique case (idx)
                    REG_DRIVE:  drive_reg  <= pwdata[DRIVE_W-1:0];
                    REG_RANGE:  range_reg  <= pwdata[RANGE_W-1:0];
                    REG_BLEND:  blend_reg  <= pwdata[BLEND_W-1:0];
                    REG_VOLUME: volume_reg <= pwdata[VOLUME_W-1:0];
                    REG_BYPASS: bypass_reg <= pwdata[0];
                    default:    ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DRIVE:  prdata = DATA_W'(drive_reg);
            REG_RANGE:  prdata = DATA_W'(range_reg);
            REG_BLEND:  prdata = DATA_W'(blend_reg);
            REG_VOLUME: prdata = DATA_W'(volume_reg);
            REG_BYPASS: prdata = DATA_W'(bypass_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.drive_range = dr_reg;
    assign cfg.blend       = blend_reg;
    assign cfg.dry_gain    = dry_reg;
    assign cfg.volume      = volume_reg;
    assign cfg.bypass      = bypass_reg;

endmodule

// ===== sv/ascw_cordic_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascw_cordic_stage
// One registered vectoring CORDIC step; carries the clean sample alongside.
// ----------------------------------------------------------------------------
module ascw_cordic_stage #(
    parameter int SAMPLE_BITS = ascw_pkg::SAMPLE_BITS_DEF,
    parameter int XW          = SAMPLE_BITS + 31,
    parameter int STEP        = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic signed [SAMPLE_BITS-1:0] smp_in,
    input  logic signed [XW-1:0]          x_in,
    input  logic signed [XW-1:0]          y_in,
    input  logic signed [ascw_pkg::Z_W-1:0] z_in,
    output logic                          valid_out,
    output logic signed [SAMPLE_BITS-1:0] smp_out,
    output logic signed [XW-1:0]          x_out,
    output logic signed [XW-1:0]          y_out,
    output logic signed [ascw_pkg::Z_W-1:0] z_out
);
    import ascw_pkg::*;

    localparam logic signed [Z_W-1:0] T = atan_step(STEP);

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic signed [XW-1:0]          x_reg, x_next;
    logic signed [XW-1:0]          y_reg, y_next;
    logic signed [Z_W-1:0]         z_reg, z_next;
    logic signed [XW-1:0]          dx, dy;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[XW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + T;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - T;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smp_reg <= smp_in;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign valid_out = valid_reg;
    assign smp_out   = smp_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

// ===== sv/ascw_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascw_mix
// Wet/dry blend, halving, volume, rounding and saturation in four stages;
// bypass selects the clean sample at the last stage.
// ----------------------------------------------------------------------------
module ascw_mix #(
    parameter int SAMPLE_BITS = ascw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  ascw_pkg::ascw_cfg_t             cfg,
    input  logic                            valid_in,
    input  logic signed [SAMPLE_BITS-1:0]   smp_in,
    input  logic signed [ascw_pkg::Z_W-1:0] z_in,
    output logic                            valid_out,
    output logic signed [SAMPLE_BITS-1:0]   out_sample,
    output logic                            clipped
);
    import ascw_pkg::*;

    localparam int PW  = 50;
    localparam int MXW = 52;
    localparam int MW  = MXW - 17;
    localparam int VW  = MW + VOLUME_W + 1;
    localparam int SH  = 48 - SAMPLE_BITS;
    localparam int RW  = VW - SH;
    localparam logic signed [MXW-1:0] HALF_M = MXW'(65536);
    localparam logic signed [VW-1:0]  HALF_V = VW'(1) << (SH - 1);

    logic [3:0]                    valid_reg;
    logic signed [SAMPLE_BITS-1:0] smp1_reg, smp2_reg, smp3_reg;

    logic signed [31:0]            xs;
    logic signed [PW-1:0]          wet_next, dry_next;
    logic signed [PW-1:0]          wet_reg, dry_reg;

    logic signed [MXW-1:0]         mix;
    logic signed [MW-1:0]          m_next, m_reg;

    logic signed [VW-1:0]          mv_next, mv_reg;

    logic signed [VW-1:0]          rnd;
    logic signed [RW-1:0]          v;
    logic                          ovf;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic signed [SAMPLE_BITS-1:0] out_next, out_reg;
    logic                          clip_next, clip_reg;

    always_comb
    begin
        xs       = 32'(smp_in) <<< (32 - SAMPLE_BITS);
        wet_next = PW'(z_in) * PW'($signed({1'b0, cfg.blend}));
        dry_next = PW'(xs) * PW'($signed(cfg.dry_gain));

        mix    = (MXW'(wet_reg) <<< 1) + MXW'(dry_reg) + HALF_M;
        m_next = mix[MXW-1:17];

        mv_next = VW'(m_reg) * VW'($signed({1'b0, cfg.volume}));

        rnd = mv_reg + HALF_V;
        v   = rnd[VW-1:SH];
        ovf = (v[RW-1:SAMPLE_BITS-1] != '0) && (v[RW-1:SAMPLE_BITS-1] != '1);
        if (!ovf)
            sat = v[SAMPLE_BITS-1:0];
        else if (v[RW-1])
            sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

        if (cfg.bypass)
        begin
            out_next  = smp3_reg;
            clip_next = 1'b0;
        end
        else
        begin
            out_next  = sat;
            clip_next = ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smp1_reg <= smp_in;
            wet_reg  <= wet_next;
            dry_reg  <= dry_next;
            smp2_reg <= smp1_reg;
            m_reg    <= m_next;
            smp3_reg <= smp2_reg;
            mv_reg   <= mv_next;
            out_reg  <= out_next;
            clip_reg <= clip_next;
        end
    end

    assign valid_out  = valid_reg[3];
    assign out_sample = out_reg;
    assign clipped    = clip_reg;

endmodule

// ===== sv/atan_soft_clip_waveshaper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_soft_clip_waveshaper_core
// (2/pi)*atan soft clipper with drive, blend, volume and bypass; APB config.
// Pipeline: 37 register stages (input reg, drive multiply, 30 CORDIC steps,
//   4 mix stages, output register).
// Throughput: one item per cycle; output register plus one skid entry, the
//   pipeline stalls only once both hold a result.
// Reset: valid bits cleared, registers to defaults (drive 1.0, range 1,
//   blend fully shaped, volume 1.0, bypass off).
// ----------------------------------------------------------------------------
module atan_soft_clip_waveshaper_core #(
    parameter int SAMPLE_BITS = ascw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ascw_in_if.sink                     sample_ch,
    ascw_out_if.source                  result_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ascw_pkg::ADDR_W-1:0] paddr,
    input  logic [ascw_pkg::DATA_W-1:0] pwdata,
    output logic [ascw_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ascw_pkg::*;

    localparam int XW = SAMPLE_BITS + 31;
    localparam int F  = SAMPLE_BITS + 15;
    localparam logic signed [XW-1:0] X_ONE = XW'(1) << F;

    ascw_cfg_t cfg;

    logic en;
    logic take;
    logic res_push;

    logic                          v0_reg, v1_reg;
    logic signed [SAMPLE_BITS-1:0] x0_reg, x1_reg;
    logic signed [XW-1:0]          p_next, p_reg;

    logic                          cv [0:CORDIC_STEPS];
    logic signed [SAMPLE_BITS-1:0] cs [0:CORDIC_STEPS];
    logic signed [XW-1:0]          cx [0:CORDIC_STEPS];
    logic signed [XW-1:0]          cy [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]         cz [0:CORDIC_STEPS];

    logic                          mix_valid;
    logic signed [SAMPLE_BITS-1:0] mix_sample;
    logic                          mix_clip;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          out_clip_reg, out_clip_next;
    logic                          skid_valid_reg, skid_valid_next;
    logic signed [SAMPLE_BITS-1:0] skid_sample_reg;
    logic                          skid_clip_reg;

    ascw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en              = !skid_valid_reg;
    assign sample_ch.ready = en;

    assign p_next = XW'(x0_reg) * XW'($signed({1'b0, cfg.drive_range}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= sample_ch.valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= sample_ch.in_sample;
            x1_reg <= x0_reg;
            p_reg  <= p_next;
        end
    end

    assign cv[0] = v1_reg;
    assign cs[0] = x1_reg;
    assign cx[0] = X_ONE;
    assign cy[0] = p_reg;
    assign cz[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        ascw_cordic_stage #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .XW          (XW),
            .STEP        (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cv[i]),
            .smp_in    (cs[i]),
            .x_in      (cx[i]),
            .y_in      (cy[i]),
            .z_in      (cz[i]),
            .valid_out (cv[i+1]),
            .smp_out   (cs[i+1]),
            .x_out     (cx[i+1]),
            .y_out     (cy[i+1]),
            .z_out     (cz[i+1])
        );
    end

    ascw_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg),
        .valid_in   (cv[CORDIC_STEPS]),
        .smp_in     (cs[CORDIC_STEPS]),
        .z_in       (cz[CORDIC_STEPS]),
        .valid_out  (mix_valid),
        .out_sample (mix_sample),
        .clipped    (mix_clip)
    );

    always_comb
    begin
        take            = !out_valid_reg || result_ch.ready;
        res_push        = en && mix_valid;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_clip_next   = out_clip_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            out_valid_next  = skid_valid_reg || res_push;
            out_sample_next = skid_valid_reg ? skid_sample_reg : mix_sample;
            out_clip_next   = skid_valid_reg ? skid_clip_reg : mix_clip;
            skid_valid_next = 1'b0;
        end
        else if (res_push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_clip_reg   <= out_clip_next;
        if (!take && res_push)
        begin
            skid_sample_reg <= mix_sample;
            skid_clip_reg   <= mix_clip;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.out_sample = out_sample_reg;
    assign result_ch.clipped    = out_clip_reg;

endmodule

// ===== dv/tb_atan_soft_clip_waveshaper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atan_soft_clip_waveshaper_core
// Self-checking bench for the arctangent soft-clip waveshaper. A directed
// table walks the sample extremes under fixed gain settings (reset values,
// bypass, hard drive, dry-only, mute, blend above one), then random phases
// reprogram every register over APB and stream random samples in bursts.
// Each output item is compared against its table value or a bit-exact CORDIC/mix predictor.
// ----------------------------------------------------------------------------
module tb_atan_soft_clip_waveshaper_core;
    import ascw_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 47;

    typedef struct packed {
        logic [31:0] drive;
        logic [31:0] pre_gain;
        logic [31:0] blend;
        logic [31:0] volume;
        logic [31:0] bypass;
    } gain_set_t;

    typedef struct packed {
        logic [2:0]           preset;
        logic signed [SB-1:0] smp;
        logic                 typed;
        logic signed [SB-1:0] t_out;
        logic                 t_clip;
    } probe_row_t;

    typedef struct {
        logic signed [SB-1:0] out_sample;
        logic                 clipped;
    } shaped_t;

    // round(atan(2^-i) * 2^31 / pi)
    localparam longint ATAN_Q31 [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41,
        20, 10, 5, 3, 1
    };

    localparam gain_set_t PRESETS [0:5] = '{
        '{32'd65536,  32'd1,    32'd65536,  32'd65536,  32'd0},  // reset values
        '{32'd65536,  32'd1,    32'd65536,  32'd65536,  32'd1},  // bypass
        '{32'd131071, 32'd4095, 32'd65536,  32'd262143, 32'd0},  // hard drive
        '{32'd0,      32'd0,    32'd0,      32'd262143, 32'd0},  // dry only, loud
        '{32'd1234,   32'd7,    32'd131071, 32'd0,      32'd0},  // muted
        '{32'd65536,  32'd16,   32'd131071, 32'd65536,  32'd0}   // blend above one
    };

    localparam probe_row_t PROBES [0:24] = '{
        '{3'd0, 24'h000000, 1'b1, 24'h000000, 1'b0},
        '{3'd0, 24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
        '{3'd0, 24'h800000, 1'b0, 24'h000000, 1'b0},
        '{3'd0, 24'h000001, 1'b0, 24'h000000, 1'b0},
        '{3'd0, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
        '{3'd0, 24'h400000, 1'b0, 24'h000000, 1'b0},
        '{3'd0, 24'hBFFFFF, 1'b0, 24'h000000, 1'b0},
        '{3'd1, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0},
        '{3'd1, 24'h800000, 1'b1, 24'h800000, 1'b0},
        '{3'd1, 24'h000000, 1'b1, 24'h000000, 1'b0},
        '{3'd1, 24'h5A5A5A, 1'b1, 24'h5A5A5A, 1'b0},
        '{3'd1, 24'hA5A5A5, 1'b1, 24'hA5A5A5, 1'b0},
        '{3'd2, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b1},
        '{3'd2, 24'h800000, 1'b1, 24'h800000, 1'b1},
        '{3'd2, 24'h000001, 1'b0, 24'h000000, 1'b0},
        '{3'd2, 24'h000000, 1'b1, 24'h000000, 1'b0},
        '{3'd3, 24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b1},
        '{3'd3, 24'h800000, 1'b1, 24'h800000, 1'b1},
        '{3'd3, 24'h010000, 1'b0, 24'h000000, 1'b0},
        '{3'd3, 24'h000000, 1'b1, 24'h000000, 1'b0},
        '{3'd4, 24'h7FFFFF, 1'b1, 24'h000000, 1'b0},
        '{3'd4, 24'h800000, 1'b1, 24'h000000, 1'b0},
        '{3'd5, 24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
        '{3'd5, 24'h800000, 1'b0, 24'h000000, 1'b0},
        '{3'd5, 24'h2DC6C0, 1'b0, 24'h000000, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ascw_in_if  #(.SAMPLE_BITS(SB)) smp_if ();
    ascw_out_if #(.SAMPLE_BITS(SB)) res_if ();

    atan_soft_clip_waveshaper_core #(.SAMPLE_BITS(SB)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (smp_if),
        .result_ch (res_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // register shadow
    logic [DRIVE_W-1:0]  cfg_drive  = DRIVE_RST;
    logic [RANGE_W-1:0]  cfg_pre    = RANGE_RST;
    logic [BLEND_W-1:0]  cfg_blend  = BLEND_RST;
    logic [VOLUME_W-1:0] cfg_volume = VOLUME_RST;
    logic                cfg_bypass = 1'b0;

    shaped_t shaped_q [$];
    shaped_t exp_r;
    int errors    = 0;
    int n_items   = 0;
    int n_checked = 0;
    int n_clipped = 0;
    int n_settings = 1;
    int cycles    = 0;
    int burst_left = 0;
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_hold   = 0;

    function automatic shaped_t shape_sample(input logic signed [SB-1:0] s);
        shaped_t r;
        longint x, p, xc, yc, zc, dx, dy, wet, dry, m, v, top;
        top = longint'(1) <<< (SB - 1);
        if (cfg_bypass)
        begin
            r.out_sample = s;
            r.clipped = 1'b0;
            return r;
        end
        x  = longint'(s);
        p  = x * (longint'(cfg_drive) * longint'(cfg_pre));
        xc = longint'(1) <<< (SB - 1 + 16);
        yc = p;
        zc = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = yc >>> i;
            dy = xc >>> i;
            if (yc >= 0)
            begin
                xc += dx;
                yc -= dy;
                zc += ATAN_Q31[i];
            end
            else
            begin
                xc -= dx;
                yc += dy;
                zc -= ATAN_Q31[i];
            end
        end
        wet = zc * 2 * longint'(cfg_blend);
        dry = x * (longint'(1) <<< (32 - SB)) * (longint'(65536) - longint'(cfg_blend));
        m = (wet + dry + (longint'(1) <<< 16)) >>> 17;
        v = (m * longint'(cfg_volume) + (longint'(1) <<< (47 - SB))) >>> (48 - SB);
        r.clipped = 1'b1;
        if (v > top - 1)
            v = top - 1;
        else if (v < -top)
            v = -top;
        else
            r.clipped = 1'b0;
        r.out_sample = v[SB-1:0];
        return r;
    endfunction

    task automatic reg_write(input ascw_reg_e r, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_DRIVE:  cfg_drive  = d[DRIVE_W-1:0];
            REG_RANGE:  cfg_pre    = d[RANGE_W-1:0];
            REG_BLEND:  cfg_blend  = d[BLEND_W-1:0];
            REG_VOLUME: cfg_volume = d[VOLUME_W-1:0];
            REG_BYPASS: cfg_bypass = d[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // junk sets bits above each register's width; they must be dropped
    task automatic apply_gains(input gain_set_t g, input bit junk);
        logic [31:0] hi;
        hi = junk ? $urandom() : 32'd0;
        reg_write(REG_DRIVE,  {hi[31:DRIVE_W],  g.drive[DRIVE_W-1:0]});
        reg_write(REG_RANGE,  {hi[31:RANGE_W],  g.pre_gain[RANGE_W-1:0]});
        reg_write(REG_BLEND,  {hi[31:BLEND_W],  g.blend[BLEND_W-1:0]});
        reg_write(REG_VOLUME, {hi[31:VOLUME_W], g.volume[VOLUME_W-1:0]});
        reg_write(REG_BYPASS, {hi[31:1],        g.bypass[0]});
        n_settings++;
    endtask

    task automatic drain_results();
        smp_if.valid <= 1'b0;
        while (shaped_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic push_sample(input logic signed [SB-1:0] s, input bit typed,
                               input logic signed [SB-1:0] t_out, input logic t_clip);
        shaped_t e;
        int gap;
        smp_if.in_sample <= s;
        smp_if.valid     <= 1'b1;
        @(posedge clk);
        while (smp_if.ready !== 1'b1)
            @(posedge clk);
        if (typed)
        begin
            e.out_sample = t_out;
            e.clipped = t_clip;
        end
        else
            e = shape_sample(s);
        shaped_q.push_back(e);
        n_items++;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    function automatic logic [31:0] pick_gain(input logic [31:0] top_val,
                                              input logic [31:0] unity);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return unity;
            2: return top_val;
            3: return $urandom_range(0, top_val >> 6);
            default: return $urandom_range(0, top_val);
        endcase
    endfunction

    function automatic logic signed [SB-1:0] pick_sample();
        logic signed [SB-1:0] s;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: s = {1'b0, {(SB-1){1'b1}}};
                    1: s = {1'b1, {(SB-1){1'b0}}};
                    2: s = '0;
                    3: s = SB'(1);
                    default: s = '1;
                endcase
            end
            1, 2, 3: s = SB'(int'($urandom_range(0, 131071)) - 65536);
            default: s = SB'($urandom());
        endcase
        return s;
    endfunction

    // result side: check, then stall pattern
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (shaped_q.size() == 0)
            begin
                $error("unexpected item: out_sample %0d clipped %0b",
                       res_if.out_sample, res_if.clipped);
                errors++;
            end
            else
            begin
                exp_r = shaped_q.pop_front();
                n_checked++;
                if (res_if.clipped === 1'b1)
                    n_clipped++;
                if (res_if.out_sample !== exp_r.out_sample)
                begin
                    $error("out_sample: expected %0d, got %0d",
                           exp_r.out_sample, res_if.out_sample);
                    errors++;
                end
                if (res_if.clipped !== exp_r.clipped)
                begin
                    $error("clipped: expected %0b, got %0b", exp_r.clipped, res_if.clipped);
                    errors++;
                end
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(16, 160);
        end
        else
            rx_left--;
        case (rx_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    res_if.ready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    rx_hold = $urandom_range(1, 15);
                    res_if.ready <= 1'b0;
                end
                else
                    res_if.ready <= 1'b1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int cur_preset;
        gain_set_t g;
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        smp_if.valid     <= 1'b0;
        smp_if.in_sample <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, first rows run on reset values
        cur_preset = 0;
        foreach (PROBES[i])
        begin
            if (int'(PROBES[i].preset) != cur_preset)
            begin
                drain_results();
                cur_preset = PROBES[i].preset;
                apply_gains(PRESETS[cur_preset], 1'b0);
            end
            push_sample(PROBES[i].smp, PROBES[i].typed, PROBES[i].t_out, PROBES[i].t_clip);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_results();
            g.drive    = pick_gain(32'd131071, 32'd65536);
            g.pre_gain = pick_gain(32'd4095, 32'd1);
            g.blend    = pick_gain(32'd131071, 32'd65536);
            g.volume   = pick_gain(32'd262143, 32'd65536);
            g.bypass   = ($urandom_range(0, 5) == 0) ? 32'd1 : 32'd0;
            apply_gains(g, ph[0]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                push_sample(pick_sample(), 1'b0, '0, 1'b0);
                if (ph == 3 && k == 20)
                    drain_results();
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        $display("Streamed %0d items over %0d gain settings; %0d results checked, %0d clipped.",
                 n_items, n_settings, n_checked, n_clipped);
        if (errors == 0 && shaped_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ascw_pkg.sv
sv/ascw_in_if.sv
sv/ascw_out_if.sv
sv/ascw_cfg.sv
sv/ascw_cordic_stage.sv
sv/ascw_mix.sv
sv/atan_soft_clip_waveshaper_core.sv
dv/tb_atan_soft_clip_waveshaper_core.sv
